>>> rtl/dpod_pkg.sv
// Shared types, constants and calendar tables for the date period overlap block.
package dpod_pkg;

   // Field widths of one request and one response
   localparam int YEAR_W      = 14;
   localparam int MONTH_W     = 4;
   localparam int DAY_W       = 5;
   localparam int DATE_W      = YEAR_W + MONTH_W + DAY_W;
   localparam int NUM_DATES   = 4;
   localparam int REQ_DATA_W  = ((NUM_DATES * DATE_W + 7) / 8) * 8;
   localparam int COUNT_W     = 22;
   localparam int RSP_DATA_W  = ((COUNT_W + 7) / 8) * 8;
   localparam int RSP_USER_W  = 1;

   // Calendar constants
   localparam int YEAR_MIN      = 1;
   localparam int YEAR_MAX      = 9999;
   localparam int MONTH_MIN     = 1;
   localparam int MONTH_MAX     = 12;
   localparam int MONTH_FEB     = 2;
   localparam int EPOCH_SHIFT   = 4800;
   localparam int MONTHS_SHIFT  = 9;
   localparam int MONTH_BACK    = 3;
   localparam int DAYS_PER_YEAR = 365;
   localparam int CENTURY       = 100;

   // Reciprocal of one hundred: x / 100 == (x * RECIP_100) >> RECIP_SHIFT for x < 2**15
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;

   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [14:0]        shifted_year_type;
   typedef logic [26:0]        yprod_type;
   typedef logic [27:0]        syprod_type;
   typedef logic [7:0]         cent_type;
   typedef logic [8:0]         day_off_type;
   typedef logic [23:0]        daynum_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      year_type  year;
      month_type month;
      day_type   day;
   } date_type;

   // Load enables of the three conversion stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // Days before the shifted month (March is zero): (153 * mm + 2) / 5
   function automatic day_off_type month_offset(input month_type mm);
      day_off_type off;
      case (mm)
         4'd0:    off = 9'd0;
         4'd1:    off = 9'd31;
         4'd2:    off = 9'd61;
         4'd3:    off = 9'd92;
         4'd4:    off = 9'd122;
         4'd5:    off = 9'd153;
         4'd6:    off = 9'd184;
         4'd7:    off = 9'd214;
         4'd8:    off = 9'd245;
         4'd9:    off = 9'd275;
         4'd10:   off = 9'd306;
         4'd11:   off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

   // Length of a calendar month
   function automatic day_type month_len(input month_type m, input logic leap);
      day_type len;
      case (m)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4,
         4'd6,
         4'd9,
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

>>> rtl/dpod_day_number.sv
// Three-stage conversion of one calendar date into a serial day number and a validity flag.
module dpod_day_number (
   input  logic                  clock,
   input  dpod_pkg::stage_en_type stage_en,
   input  dpod_pkg::date_type     date,
   output dpod_pkg::daynum_type   day_num,
   output logic                  date_ok
);

   // Stage 1: shift the year to start in March, take reciprocal products
   logic                        a_in;
   dpod_pkg::year_type          y_ff;
   dpod_pkg::month_type         m_ff;
   dpod_pkg::day_type           d_ff;
   dpod_pkg::shifted_year_type  yy_in, yy_ff;
   dpod_pkg::month_type         mm_in, mm_ff;
   dpod_pkg::yprod_type         py_in, py_ff;
   dpod_pkg::syprod_type        pyy_in, pyy_ff;
   logic                        ok1_in, ok1_ff;

   always_comb begin
      a_in   = (date.month <= dpod_pkg::month_type'(dpod_pkg::MONTH_FEB));
      yy_in  = dpod_pkg::shifted_year_type'(date.year)
             + dpod_pkg::shifted_year_type'(dpod_pkg::EPOCH_SHIFT)
             - dpod_pkg::shifted_year_type'(a_in);
      mm_in  = a_in ? date.month + dpod_pkg::month_type'(dpod_pkg::MONTHS_SHIFT)
                    : date.month - dpod_pkg::month_type'(dpod_pkg::MONTH_BACK);
      py_in  = dpod_pkg::yprod_type'(date.year)
             * dpod_pkg::yprod_type'(dpod_pkg::RECIP_100);
      pyy_in = dpod_pkg::syprod_type'(yy_in)
             * dpod_pkg::syprod_type'(dpod_pkg::RECIP_100);
      ok1_in = (date.year >= dpod_pkg::year_type'(dpod_pkg::YEAR_MIN))
            && (date.year <= dpod_pkg::year_type'(dpod_pkg::YEAR_MAX))
            && (date.month >= dpod_pkg::month_type'(dpod_pkg::MONTH_MIN))
            && (date.month <= dpod_pkg::month_type'(dpod_pkg::MONTH_MAX))
            && (date.day != '0);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         y_ff   <= date.year;
         m_ff   <= date.month;
         d_ff   <= date.day;
         yy_ff  <= yy_in;
         mm_ff  <= mm_in;
         py_ff  <= py_in;
         pyy_ff <= pyy_in;
         ok1_ff <= ok1_in;
      end
   end

   // Stage 2: leap year and day range check, year and month partial terms
   dpod_pkg::cent_type          qy_in;
   dpod_pkg::year_type          cmul_in;
   logic                        leap_in;
   logic                        ok2_in, ok2_ff;
   dpod_pkg::day_off_type       day_off_in, day_off_ff;
   dpod_pkg::daynum_type        yr365_in, yr365_ff;
   dpod_pkg::shifted_year_type  yy4_in, yy4_ff;
   dpod_pkg::cent_type          q100_in, q100_ff;

   always_comb begin
      qy_in      = dpod_pkg::cent_type'(py_ff >> dpod_pkg::RECIP_SHIFT);
      cmul_in    = dpod_pkg::year_type'(qy_in) * dpod_pkg::year_type'(dpod_pkg::CENTURY);
      leap_in    = (y_ff[1:0] == 2'b00) && ((y_ff != cmul_in) || (qy_in[1:0] == 2'b00));
      ok2_in     = ok1_ff && (d_ff <= dpod_pkg::month_len(m_ff, leap_in));
      day_off_in = dpod_pkg::day_off_type'(d_ff) + dpod_pkg::month_offset(mm_ff);
      yr365_in   = dpod_pkg::daynum_type'(yy_ff)
                 * dpod_pkg::daynum_type'(dpod_pkg::DAYS_PER_YEAR);
      yy4_in     = yy_ff >> 2;
      q100_in    = dpod_pkg::cent_type'(pyy_ff >> dpod_pkg::RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         ok2_ff     <= ok2_in;
         day_off_ff <= day_off_in;
         yr365_ff   <= yr365_in;
         yy4_ff     <= yy4_in;
         q100_ff    <= q100_in;
      end
   end

   // Stage 3: sum the terms into the serial day number
   dpod_pkg::daynum_type n_in, n_ff;
   logic                 ok3_ff;

   always_comb begin
      n_in = yr365_ff
           + dpod_pkg::daynum_type'(yy4_ff)
           + dpod_pkg::daynum_type'(day_off_ff)
           + dpod_pkg::daynum_type'(q100_ff >> 2)
           - dpod_pkg::daynum_type'(q100_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         n_ff   <= n_in;
         ok3_ff <= ok2_ff;
      end
   end

   assign day_num = n_ff;
   assign date_ok = ok3_ff;

endmodule

>>> rtl/date_period_overlap_days_top.sv
// Top level of the date period overlap counter: request unpacking, stage control, overlap.
//
//   channel  direction  tdata                               tuser
//   req_     in         four dates, 23 bits each, 96 total  -
//   rsp_     out        overlap_days, 24 bits               date_invalid
//
// One request is taken every cycle unless a stalled response has backed up the full pipeline.
// Three stages convert each date to a day number, one picks the later start and the
// earlier end, and the response register forms the inclusive count.
// Each stage loads when it is empty or the stage after it moves, so bubbles are absorbed
// and a stalled response does not block requests until the pipeline is full.
// Reset clears the valid bits only; a stall loses and repeats nothing.
module date_period_overlap_days_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // fields from bit 0 up, per date (first start, first end, second start, second end):
   // year[13:0], month[3:0], day[4:0]; top four bits zero
   input  logic [dpod_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // overlap_days[21:0], two zero bits
   output logic [dpod_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // date_invalid
   output logic [dpod_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   // Stage valid bits and load enables
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic                  rdy1, rdy2, rdy3, rdy4, rdy5;
   dpod_pkg::stage_en_type stage_en;

   always_comb begin
      rdy5        = !rsp_tvalid || rsp_tready;
      rdy4        = !v4_ff || rdy5;
      rdy3        = !v3_ff || rdy4;
      rdy2        = !v2_ff || rdy3;
      rdy1        = !v1_ff || rdy2;
      stage_en.s1 = rdy1;
      stage_en.s2 = rdy2;
      stage_en.s3 = rdy3;
      req_tready  = rdy1;
   end

   // Advance the valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) rsp_tvalid <= v4_ff;
      end
   end

   // Convert the four dates of the request
   dpod_pkg::daynum_type day_num [dpod_pkg::NUM_DATES];
   logic                 date_ok [dpod_pkg::NUM_DATES];

   for (genvar k = 0; k < dpod_pkg::NUM_DATES; k++) begin : g_date
      dpod_pkg::date_type date;

      assign date.year  = req_tdata[k*dpod_pkg::DATE_W +: dpod_pkg::YEAR_W];
      assign date.month = req_tdata[k*dpod_pkg::DATE_W + dpod_pkg::YEAR_W +: dpod_pkg::MONTH_W];
      assign date.day   = req_tdata[k*dpod_pkg::DATE_W + dpod_pkg::YEAR_W + dpod_pkg::MONTH_W
                                    +: dpod_pkg::DAY_W];

      dpod_day_number u_day_number (
         .clock    (clock),
         .stage_en (stage_en),
         .date     (date),
         .day_num  (day_num[k]),
         .date_ok  (date_ok[k])
      );
   end

   // Stage 4: later start, earlier end, any invalid date
   dpod_pkg::daynum_type lo_in, lo_ff, hi_in, hi_ff;
   logic                 bad_in, bad_ff;

   always_comb begin
      lo_in  = (day_num[0] > day_num[2]) ? day_num[0] : day_num[2];
      hi_in  = (day_num[1] < day_num[3]) ? day_num[1] : day_num[3];
      bad_in = !(date_ok[0] && date_ok[1] && date_ok[2] && date_ok[3]);
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         bad_ff <= bad_in;
      end
   end

   // Stage 5: inclusive count, zero when disjoint, reversed or invalid
   dpod_pkg::daynum_type diff_in;
   dpod_pkg::count_type  count_in, count_ff;
   logic                 inval_ff;

   always_comb begin
      diff_in  = hi_ff - lo_ff + dpod_pkg::daynum_type'(1);
      count_in = (!bad_ff && (hi_ff >= lo_ff)) ? dpod_pkg::count_type'(diff_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         count_ff <= count_in;
         inval_ff <= bad_ff;
      end
   end

   assign rsp_tdata = dpod_pkg::RSP_DATA_W'(count_ff);
   assign rsp_tuser = inval_ff;

endmodule

>>> rtl/dpod_checker.sv
// Port checker for the date period overlap counter, bound to the top level.
module dpod_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dpod_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [dpod_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // Hold a stalled response unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // An invalid date forces a zero count
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("invalid request gave a non-zero count");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // With no response waiting, the pipeline must take a request
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with an empty output stage");

   // Count stays within its field
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[dpod_pkg::RSP_DATA_W-1:dpod_pkg::COUNT_W] == '0)
      else $error("count overflowed its field");

endmodule

bind date_period_overlap_days_top dpod_checker u_dpod_checker (.*);

>>> tb/tb_date_period_overlap_days_top.sv
// Self-checking testbench for the date period overlap counter: directed and random requests.
`timescale 1ns / 1ps

module tb_date_period_overlap_days_top;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 20;
   localparam int NUM_RANDOM  = 700;

   typedef struct {
      dpod_pkg::year_type  year;
      dpod_pkg::month_type month;
      dpod_pkg::day_type   day;
   } cal_date_type;

   typedef struct {
      dpod_pkg::count_type days;
      logic                invalid;
   } overlap_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [dpod_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [dpod_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [dpod_pkg::RSP_USER_W-1:0] rsp_tuser;

   // High while both sides run without idling
   bit           calm;
   int unsigned  quiet_cycles;
   cal_date_type stim [4];

   // Calendar arithmetic (proleptic Gregorian)
   function automatic bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic int unsigned month_days(int unsigned y, int unsigned m);
      case (m)
         2:           return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic bit date_valid(cal_date_type dt);
      if (dt.year < 1 || dt.year > 9999) return 1'b0;
      if (dt.month < 1 || dt.month > 12) return 1'b0;
      return dt.day >= 1 && dt.day <= month_days(dt.year, dt.month);
   endfunction

   // Day count from a fixed epoch, with the year starting in March
   function automatic int unsigned serial_day(cal_date_type dt);
      int unsigned jan_feb;
      int unsigned yy;
      int unsigned mm;
      jan_feb = (dt.month <= 2) ? 1 : 0;
      yy      = dt.year + 4800 - jan_feb;
      mm      = dt.month + 12 * jan_feb - 3;
      return dt.day + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400;
   endfunction

   function automatic cal_date_type mk_date(int unsigned y, int unsigned m, int unsigned d);
      cal_date_type dt;
      dt.year  = dpod_pkg::year_type'(y);
      dt.month = dpod_pkg::month_type'(m);
      dt.day   = dpod_pkg::day_type'(d);
      return dt;
   endfunction

   // Pack four dates into a request word, first date in the lowest bits
   function automatic logic [dpod_pkg::REQ_DATA_W-1:0] pack_dates(
         cal_date_type a, cal_date_type b, cal_date_type c, cal_date_type d);
      logic [dpod_pkg::REQ_DATA_W-1:0] word;
      cal_date_type                    four [4];
      four = '{a, b, c, d};
      word = '0;
      for (int i = 0; i < dpod_pkg::NUM_DATES; i++) begin
         word[i*dpod_pkg::DATE_W +: dpod_pkg::YEAR_W] = four[i].year;
         word[i*dpod_pkg::DATE_W + dpod_pkg::YEAR_W +: dpod_pkg::MONTH_W] = four[i].month;
         word[i*dpod_pkg::DATE_W + dpod_pkg::YEAR_W + dpod_pkg::MONTH_W
              +: dpod_pkg::DAY_W] = four[i].day;
      end
      return word;
   endfunction

   class overlap_scoreboard;
      overlap_type expected_q [$];
      int unsigned errors;

      function new();
         errors = 0;
      endfunction

      // Predict the response of one accepted request
      function void note_request(logic [dpod_pkg::REQ_DATA_W-1:0] word);
         cal_date_type dt;
         int unsigned  num [4];
         int unsigned  lo;
         int unsigned  hi;
         overlap_type  exp_rsp;
         exp_rsp.days    = '0;
         exp_rsp.invalid = 1'b0;
         for (int i = 0; i < dpod_pkg::NUM_DATES; i++) begin
            dt.year  = word[i*dpod_pkg::DATE_W +: dpod_pkg::YEAR_W];
            dt.month = word[i*dpod_pkg::DATE_W + dpod_pkg::YEAR_W +: dpod_pkg::MONTH_W];
            dt.day   = word[i*dpod_pkg::DATE_W + dpod_pkg::YEAR_W + dpod_pkg::MONTH_W
                            +: dpod_pkg::DAY_W];
            if (!date_valid(dt)) begin
               exp_rsp.invalid = 1'b1;
               num[i] = 0;
            end else begin
               num[i] = serial_day(dt);
            end
         end
         if (!exp_rsp.invalid) begin
            lo = (num[0] > num[2]) ? num[0] : num[2];
            hi = (num[1] < num[3]) ? num[1] : num[3];
            if (hi >= lo) exp_rsp.days = dpod_pkg::count_type'(hi - lo + 1);
         end
         expected_q.push_back(exp_rsp);
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(logic [dpod_pkg::RSP_DATA_W-1:0] word,
                                   logic [dpod_pkg::RSP_USER_W-1:0] user);
         overlap_type exp_rsp;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding: overlap_days %0d, date_invalid %0d",
                   word[dpod_pkg::COUNT_W-1:0], user[0]);
            errors++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (word[dpod_pkg::COUNT_W-1:0] !== exp_rsp.days) begin
            $error("overlap_days: expected %0d, got %0d", exp_rsp.days,
                   word[dpod_pkg::COUNT_W-1:0]);
            errors++;
         end
         if (user[0] !== exp_rsp.invalid) begin
            $error("date_invalid: expected %0d, got %0d", exp_rsp.invalid, user[0]);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   overlap_scoreboard sb = new();

   date_period_overlap_days_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("[date_period_overlap_days_top] ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Response side: stall at random
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      stall      = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   // Drive one request and hold it until accepted
   task automatic send_periods(cal_date_type a, cal_date_type b,
                               cal_date_type c, cal_date_type d);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= pack_dates(a, b, c, d);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_cycles(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   function automatic cal_date_type near_date(int base, int spread);
      int           y;
      cal_date_type dt;
      y = base - spread + int'($urandom_range(0, 2 * spread));
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
      dt.year  = dpod_pkg::year_type'(y);
      dt.month = dpod_pkg::month_type'($urandom_range(1, 12));
      dt.day   = dpod_pkg::day_type'($urandom_range(1, month_days(dt.year, dt.month)));
      return dt;
   endfunction

   function automatic cal_date_type raw_date();
      return mk_date($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
   endfunction

   // Break one field of a valid date
   function automatic cal_date_type spoil_date(cal_date_type dt);
      int unsigned len;
      case ($urandom_range(0, 2))
         0: dt.year = $urandom_range(0, 1) ? dpod_pkg::year_type'(0)
                      : dpod_pkg::year_type'($urandom_range(10000, 16383));
         1: dt.month = $urandom_range(0, 1) ? dpod_pkg::month_type'(0)
                       : dpod_pkg::month_type'($urandom_range(13, 15));
         default: begin
            len = month_days(dt.year, dt.month);
            if (len == 31 || $urandom_range(0, 3) == 0) dt.day = '0;
            else dt.day = dpod_pkg::day_type'($urandom_range(len + 1, 31));
         end
      endcase
      return dt;
   endfunction

   // Fill the stimulus dates with one random request
   task automatic make_random_item();
      int unsigned kind;
      int unsigned r;
      int          base;
      int          spread;
      kind = $urandom_range(0, 99);
      base = $urandom_range(1, 9999);
      r    = $urandom_range(0, 99);
      if (r < 50) spread = 0;
      else if (r < 80) spread = $urandom_range(1, 3);
      else if (r < 95) spread = $urandom_range(4, 100);
      else spread = $urandom_range(101, 5000);
      if (kind >= 95) begin
         base   = 5000;
         spread = 9999;
      end
      for (int i = 0; i < dpod_pkg::NUM_DATES; i++) begin
         if (kind >= 85 && kind < 95) stim[i] = raw_date();
         else stim[i] = near_date(base, spread);
      end
      if (kind >= 75 && kind < 85) begin
         r = $urandom_range(0, dpod_pkg::NUM_DATES - 1);
         stim[r] = spoil_date(stim[r]);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      calm       = 1'b0;
      quiet_cycles = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full span, disjoint, reversed, touching, leap days, broken fields
      send_periods(mk_date(1, 1, 1), mk_date(9999, 12, 31),
                   mk_date(1, 1, 1), mk_date(9999, 12, 31));
      send_periods(mk_date(2000, 1, 1), mk_date(2000, 1, 31),
                   mk_date(2000, 2, 1), mk_date(2000, 2, 28));
      send_periods(mk_date(2001, 5, 10), mk_date(2001, 5, 1),
                   mk_date(2001, 1, 1), mk_date(2001, 12, 31));
      send_periods(mk_date(2001, 1, 1), mk_date(2001, 12, 31),
                   mk_date(2001, 8, 1), mk_date(2001, 7, 31));
      send_periods(mk_date(2020, 3, 1), mk_date(2020, 3, 15),
                   mk_date(2020, 3, 15), mk_date(2020, 4, 1));
      send_periods(mk_date(2000, 2, 29), mk_date(2000, 2, 29),
                   mk_date(2000, 2, 29), mk_date(2000, 2, 29));
      send_periods(mk_date(1900, 2, 29), mk_date(1900, 3, 1),
                   mk_date(1900, 1, 1), mk_date(1900, 12, 31));
      send_periods(mk_date(2004, 1, 1), mk_date(2004, 12, 31),
                   mk_date(2004, 2, 29), mk_date(2005, 1, 10));
      send_periods(mk_date(2001, 1, 1), mk_date(2001, 12, 31),
                   mk_date(2001, 2, 29), mk_date(2001, 3, 1));
      send_periods(mk_date(2010, 6, 0), mk_date(2010, 6, 30),
                   mk_date(2010, 1, 1), mk_date(2010, 12, 31));
      send_periods(mk_date(2010, 1, 1), mk_date(2010, 4, 31),
                   mk_date(2010, 1, 1), mk_date(2010, 12, 31));
      send_periods(mk_date(2010, 1, 1), mk_date(2010, 12, 31),
                   mk_date(2010, 0, 5), mk_date(2010, 12, 31));
      send_periods(mk_date(2010, 1, 1), mk_date(2010, 12, 31),
                   mk_date(2010, 1, 1), mk_date(2010, 13, 1));
      send_periods(mk_date(2010, 15, 1), mk_date(2010, 12, 31),
                   mk_date(2010, 1, 1), mk_date(2010, 12, 31));
      send_periods(mk_date(0, 1, 1), mk_date(2010, 12, 31),
                   mk_date(2010, 1, 1), mk_date(2010, 12, 31));
      send_periods(mk_date(2010, 1, 1), mk_date(10000, 1, 1),
                   mk_date(2010, 1, 1), mk_date(2010, 12, 31));
      send_periods(mk_date(16383, 15, 31), mk_date(16383, 15, 31),
                   mk_date(16383, 15, 31), mk_date(16383, 15, 31));
      send_periods(mk_date(1999, 12, 31), mk_date(2000, 1, 1),
                   mk_date(1999, 1, 1), mk_date(2000, 12, 31));
      send_periods(mk_date(9999, 12, 31), mk_date(9999, 12, 31),
                   mk_date(9999, 1, 1), mk_date(9999, 12, 31));
      send_periods(mk_date(1, 1, 1), mk_date(1, 1, 1),
                   mk_date(1, 1, 1), mk_date(1, 1, 31));
      send_periods(mk_date(8192, 7, 31), mk_date(9000, 8, 31),
                   mk_date(1, 1, 1), mk_date(8500, 11, 30));

      // Random part with idle and calm stretches
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 100 == 0) calm = ($urandom_range(0, 2) == 0);
         // Hold off once until the pipeline has drained completely
         if (n == NUM_RANDOM / 2) begin
            idle_cycles(1);
            while (sb.pending() != 0) @(posedge clock);
         end
         make_random_item();
         if (!calm) idle_cycles(pick_gap());
         send_periods(stim[0], stim[1], stim[2], stim[3]);
      end
      idle_cycles(1);

      // Drain, then allow for anything arriving late
      calm = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[date_period_overlap_days_top] OK");
      end else begin
         $display("[date_period_overlap_days_top] ERROR");
      end
      $finish;
   end

endmodule
